FILE: design/pet_pkg.sv
// Shared types, codes and defaults for the periodic event timer bank.
package pet_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int TIME_BITS_DEF  = 24;

  localparam logic [1:0] MODE_ARM    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_FIRE = 2'd1;
  localparam logic [1:0] KIND_IDLE = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BUSY     = 2'd1;
  localparam logic [1:0] STATUS_ZERO_PER = 2'd2;
  localparam logic [1:0] STATUS_INACTIVE = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  slot_index;
    logic [23:0] period_ms;
    logic [15:0] repeat_count;
    logic [23:0] elapsed_ms;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] fired_slot;
    logic [1:0] status;
    logic       last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_DIV,
    ST_WB,
    ST_FINISH
  } state_t;

endpackage

FILE: design/pet_slot_ram.sv
// Slot store: countdown, period and repeat count per slot, one write and one read port.
module pet_slot_ram #(
  parameter int DEPTH = pet_pkg::SLOT_COUNT_DEF,
  parameter int AW    = 4,
  parameter int TB    = pet_pkg::TIME_BITS_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [TB-1:0] wcount,
  input  logic [TB-1:0] wperiod,
  input  logic [15:0]   wreps,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [TB-1:0] rcount,
  output logic [TB-1:0] rperiod,
  output logic [15:0]   rreps
);
  import pet_pkg::*;

  logic [TB-1:0] count_mem  [DEPTH];
  logic [TB-1:0] period_mem [DEPTH];
  logic [15:0]   reps_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      count_mem[waddr]  <= wcount;
      period_mem[waddr] <= wperiod;
      reps_mem[waddr]   <= wreps;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rcount  <= count_mem[raddr];
      rperiod <= period_mem[raddr];
      rreps   <= reps_mem[raddr];
    end
  end

endmodule

FILE: design/pet_rem.sv
// Iterative remainder unit: restoring division, one dividend bit per cycle.
module pet_rem #(
  parameter int TB = pet_pkg::TIME_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [TB-1:0] dividend,
  input  logic [TB-1:0] divisor,
  output logic          done,
  output logic [TB-1:0] remainder
);
  import pet_pkg::*;

  localparam int CW = $clog2(TB + 1);

  logic          running;
  logic [CW-1:0] count;
  logic [TB-1:0] quo;
  logic [TB-1:0] dvs;
  logic [TB:0]   trial;
  logic [TB:0]   diff;

  assign trial = {remainder, quo[TB-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CW'(TB);
      end else if (running) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quo       <= dividend;
      dvs       <= divisor;
    end else if (running) begin
      quo <= {quo[TB-2:0], 1'b0};
      // subtract when the trial fits, else keep the shifted value
      if (!diff[TB]) begin
        remainder <= diff[TB-1:0];
      end else begin
        remainder <= trial[TB-1:0];
      end
    end
  end

endmodule

FILE: design/periodic_event_timer_bank.sv
// Top level: periodic timer slot bank with a tick scan sequencer.
//
//  channel   signals                     direction  handshake
//  command   start, busy, cmd            in         taken when start && !busy
//  result    result_strobe, result       out        one cycle per word, no stall
//
// Arm and cancel never leave idle; their acknowledge follows in the next cycle.
// A tick scans all SLOT_COUNT slots in order, then closes in FINISH: an inactive
// slot takes SCAN only, an active one that does not fire SCAN and EVAL, one that
// fires SCAN, EVAL, DIV and WB (the shared remainder unit takes one bit a cycle).
// Each fired word is held back until the next firing or the end of the scan,
// so last can be set on the final one. Reset clears the active bits and state.
// The receiver cannot stall; words are shown for exactly one cycle.
module periodic_event_timer_bank #(
  parameter int SLOT_COUNT = pet_pkg::SLOT_COUNT_DEF,
  parameter int TIME_BITS  = pet_pkg::TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pet_pkg::cmd_t    cmd,
  output logic             result_strobe,
  output pet_pkg::result_t result
);
  import pet_pkg::*;

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int TB = TIME_BITS;

  state_t state, state_next;

  logic [SLOT_COUNT-1:0] active;
  logic [AW-1:0]         ptr;
  logic [TB-1:0]         elapsed;
  logic                  pend_valid;
  logic [AW-1:0]         pend_slot;

  logic          accept;
  logic          idx_ok;
  logic [AW-1:0] idx;
  logic [TB-1:0] cmd_period;
  logic          ptr_last;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [TB-1:0] mem_wcount;
  logic [TB-1:0] mem_wperiod;
  logic [15:0]   mem_wreps;
  logic          mem_re;
  logic [TB-1:0] rd_count;
  logic [TB-1:0] rd_period;
  logic [15:0]   rd_reps;

  logic          rem_start;
  logic          rem_done;
  logic [TB-1:0] rem_value;

  logic          emit;
  result_t       emit_word;
  logic          set_act;
  logic          clr_act;
  logic [AW-1:0] act_addr;
  logic          ptr_clr;
  logic          ptr_inc;
  logic          pend_load;
  logic          pend_clr;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign idx_ok     = {5'd0, cmd.slot_index} < 9'(SLOT_COUNT);
  assign idx        = AW'(cmd.slot_index);
  assign cmd_period = TB'(cmd.period_ms);
  assign ptr_last   = (ptr == AW'(SLOT_COUNT - 1));

  pet_slot_ram #(.DEPTH(SLOT_COUNT), .AW(AW), .TB(TB)) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wcount  (mem_wcount),
    .wperiod (mem_wperiod),
    .wreps   (mem_wreps),
    .re      (mem_re),
    .raddr   (ptr),
    .rcount  (rd_count),
    .rperiod (rd_period),
    .rreps   (rd_reps)
  );

  pet_rem #(.TB(TB)) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (elapsed - rd_count),
    .divisor   (rd_period),
    .done      (rem_done),
    .remainder (rem_value)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cmd.mode == MODE_TICK) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (active[ptr]) begin
          state_next = ST_EVAL;
        end else if (ptr_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_EVAL: begin
        if (rd_count <= elapsed) begin
          state_next = ST_DIV;
        end else if (ptr_last) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_DIV: begin
        if (rem_done) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        state_next = ptr_last ? ST_FINISH : ST_SCAN;
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = ptr;
    mem_wcount  = rd_count;
    mem_wperiod = rd_period;
    mem_wreps   = rd_reps;
    mem_re      = 1'b0;
    rem_start   = 1'b0;
    emit        = 1'b0;
    emit_word   = '{kind: KIND_ACK, fired_slot: cmd.slot_index, status: STATUS_OK,
                    last: 1'b1};
    set_act     = 1'b0;
    clr_act     = 1'b0;
    act_addr    = ptr;
    ptr_clr     = 1'b0;
    ptr_inc     = 1'b0;
    pend_load   = 1'b0;
    pend_clr    = 1'b0;
    case (state)
      ST_IDLE: begin
        ptr_clr  = 1'b1;
        pend_clr = 1'b1;
        act_addr = idx;
        if (accept && cmd.mode == MODE_ARM) begin
          emit = 1'b1;
          if (cmd_period == '0) begin
            emit_word.status = STATUS_ZERO_PER;
          end else if (!idx_ok) begin
            emit_word.status = STATUS_INACTIVE;
          end else if (active[idx]) begin
            emit_word.status = STATUS_BUSY;
          end else begin
            set_act     = 1'b1;
            mem_we      = 1'b1;
            mem_waddr   = idx;
            mem_wcount  = cmd_period;
            mem_wperiod = cmd_period;
            mem_wreps   = cmd.repeat_count;
          end
        end else if (accept && cmd.mode == MODE_CANCEL) begin
          emit = 1'b1;
          if (!idx_ok || !active[idx]) begin
            emit_word.status = STATUS_INACTIVE;
          end else begin
            clr_act = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        mem_re = active[ptr];
        if (!active[ptr]) begin
          ptr_inc = !ptr_last;
        end
      end
      ST_EVAL: begin
        if (rd_count <= elapsed) begin
          rem_start = 1'b1;
        end else begin
          mem_we     = 1'b1;
          mem_wcount = rd_count - elapsed;
          ptr_inc    = !ptr_last;
        end
      end
      ST_WB: begin
        mem_we     = 1'b1;
        mem_wcount = (rem_value == '0) ? rd_period : (rd_period - rem_value);
        if (rd_reps > 16'd1) begin
          mem_wreps = rd_reps - 16'd1;
        end
        clr_act   = (rd_reps == 16'd1);
        pend_load = 1'b1;
        ptr_inc   = !ptr_last;
        // release the held firing now that another one follows it
        emit      = pend_valid;
        emit_word = '{kind: KIND_FIRE, fired_slot: 4'(pend_slot), status: STATUS_OK,
                      last: 1'b0};
      end
      ST_FINISH: begin
        emit = 1'b1;
        if (pend_valid) begin
          emit_word = '{kind: KIND_FIRE, fired_slot: 4'(pend_slot), status: STATUS_OK,
                        last: 1'b1};
        end else begin
          emit_word = '{kind: KIND_IDLE, fired_slot: 4'd0, status: STATUS_OK,
                        last: 1'b1};
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      active        <= '0;
      result_strobe <= 1'b0;
      pend_valid    <= 1'b0;
      ptr           <= '0;
    end else begin
      state         <= state_next;
      result_strobe <= emit;
      if (set_act) begin
        active[act_addr] <= 1'b1;
      end else if (clr_act) begin
        active[act_addr] <= 1'b0;
      end
      if (ptr_clr) begin
        ptr <= '0;
      end else if (ptr_inc) begin
        ptr <= ptr + 1'b1;
      end
      if (pend_clr) begin
        pend_valid <= 1'b0;
      end else if (pend_load) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= emit_word;
    if (pend_load) begin
      pend_slot <= ptr;
    end
    if (accept) begin
      elapsed <= TB'(cmd.elapsed_ms);
    end
  end

  a_tick_goes_busy: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.mode == MODE_TICK |=> busy)
    else $error("tick accepted but block not busy");

  a_cmd_acknowledged: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.mode == MODE_ARM || cmd.mode == MODE_CANCEL)
      |=> result_strobe && result.last && result.kind == KIND_ACK)
    else $error("arm or cancel not acknowledged");

  a_idle_word_is_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.kind == KIND_IDLE |-> result.last)
    else $error("idle tick word without last");

  a_rem_done_in_div: assert property (@(posedge clk) disable iff (rst)
    rem_done |-> state == ST_DIV)
    else $error("remainder finished outside divide wait");

  a_fire_status_ok: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.kind == KIND_FIRE |-> result.status == STATUS_OK)
    else $error("fired word with nonzero status");

endmodule
